/* sv/mbd_pkg.sv */
// Shared types and constants for the mipmap box downsampler.
package mbd_pkg;

  // Texel component layout.
  localparam int COMP_COUNT = 4;
  localparam int COMP_W     = 8;
  localparam int SUM_W      = COMP_W + 1;
  localparam int PAIR_W     = COMP_COUNT * SUM_W;

  // Image size limits.
  localparam int MAX_WIDTH_LOG2_DEFAULT = 12;
  localparam int MAX_HEIGHT_LOG2        = 12;
  localparam int ROW_W                  = MAX_HEIGHT_LOG2;

  // Configuration port.
  localparam int LOG2_W     = 4;
  localparam int CCOUNT_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH_LOG2  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT_LOG2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_COMP_COUNT  = 2'd2;

  localparam logic [LOG2_W-1:0]   WIDTH_LOG2_RESET  = 4'd1;
  localparam logic [LOG2_W-1:0]   HEIGHT_LOG2_RESET = 4'd1;
  localparam logic [CCOUNT_W-1:0] COMP_COUNT_RESET  = 3'd4;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // What the back part does with a queued word.
  typedef enum logic {
    OP_STORE = 1'b0,
    OP_EMIT  = 1'b1
  } op_t;

  typedef logic [COMP_W-1:0] comp_t;
  typedef logic [SUM_W-1:0]  sum_t;

endpackage

/* sv/mipmap_box_downsample.sv */
// Top level of the 2x2 box-filter mipmap downsampler.
//
// Texels of a power-of-two image enter in raster order on the input channel
// (in_valid, in_ready, comp0..comp3). One word of the next mipmap level
// leaves on the output channel (out_valid, out_ready, avg0..avg3,
// last_of_image) for every odd column of every odd input row; last_of_image
// marks the final word of the image. Components at or beyond
// component_count are output as zero.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready; write it only while the block is idle.
// Throughput is one texel per cycle while the queue has room, set by the
// single line-store access per pair in the back part. A result word passes
// from the queue through the registered line-store read into the output
// register, where it is presented.
// When the receiver stalls, the output register, the read stage and the
// four-entry queue fill, and only then does in_ready drop for odd columns.
// Reset clears the position counters, the left texel, the queue and the
// output valid, and restores the configuration defaults; the line store is
// not cleared and is always written on an even row before it is read.
module mipmap_box_downsample #(
  parameter int MAX_WIDTH_LOG2 = mbd_pkg::MAX_WIDTH_LOG2_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  mbd_pkg::comp_t                 comp0,
  input  mbd_pkg::comp_t                 comp1,
  input  mbd_pkg::comp_t                 comp2,
  input  mbd_pkg::comp_t                 comp3,
  output logic                           out_valid,
  input  logic                           out_ready,
  output mbd_pkg::comp_t                 avg0,
  output mbd_pkg::comp_t                 avg1,
  output mbd_pkg::comp_t                 avg2,
  output mbd_pkg::comp_t                 avg3,
  output logic                           last_of_image
);
  import mbd_pkg::*;

  localparam int ADDR_W = MAX_WIDTH_LOG2 - 1;
  localparam int QW     = 2 + ADDR_W + PAIR_W;

  logic [LOG2_W-1:0]   width_log2;
  logic [LOG2_W-1:0]   height_log2;
  logic [CCOUNT_W-1:0] component_count;

  logic              f_push;
  op_t               f_op;
  logic              f_last;
  logic [ADDR_W-1:0] f_addr;
  logic [PAIR_W-1:0] f_pair;
  logic              q_not_full;
  logic              q_not_empty;
  logic              q_pop;
  logic [QW-1:0]     q_head;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_log2      <= WIDTH_LOG2_RESET;
      height_log2     <= HEIGHT_LOG2_RESET;
      component_count <= COMP_COUNT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IDX_WIDTH_LOG2:  width_log2      <= cfg_data[LOG2_W-1:0];
        CFG_IDX_HEIGHT_LOG2: height_log2     <= cfg_data[LOG2_W-1:0];
        CFG_IDX_COMP_COUNT:  component_count <= cfg_data[CCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  mbd_front #(
    .MAX_WIDTH_LOG2 (MAX_WIDTH_LOG2)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .width_log2  (width_log2),
    .height_log2 (height_log2),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .comp0       (comp0),
    .comp1       (comp1),
    .comp2       (comp2),
    .comp3       (comp3),
    .q_ready     (q_not_full),
    .q_push      (f_push),
    .q_op        (f_op),
    .q_last      (f_last),
    .q_addr      (f_addr),
    .q_pair      (f_pair)
  );

  mbd_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .push_data ({f_op, f_last, f_addr, f_pair}),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  mbd_back #(
    .MAX_WIDTH_LOG2 (MAX_WIDTH_LOG2)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .component_count (component_count),
    .q_valid         (q_not_empty),
    .q_pop           (q_pop),
    .q_op            (op_t'(q_head[QW-1])),
    .q_last          (q_head[QW-2]),
    .q_addr          (q_head[PAIR_W +: ADDR_W]),
    .q_pair          (q_head[PAIR_W-1:0]),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .avg0            (avg0),
    .avg1            (avg1),
    .avg2            (avg2),
    .avg3            (avg3),
    .last_of_image   (last_of_image)
  );

endmodule

/* sv/mbd_ram.sv */
// Generic simple dual-port RAM with a registered read port.
module mbd_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 2048,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/mbd_queue.sv */
// Short first-in first-out queue between the front and back parts.
module mbd_queue #(
  parameter int WIDTH = 50,
  parameter int DEPTH = 4,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             not_full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] head
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign not_full  = (count != CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  // Storage is written without reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* sv/mbd_front.sv */
// Front part: accepts texels, tracks position, forms horizontal pair sums.
module mbd_front #(
  parameter int MAX_WIDTH_LOG2 = mbd_pkg::MAX_WIDTH_LOG2_DEFAULT,
  localparam int ADDR_W = MAX_WIDTH_LOG2 - 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [mbd_pkg::LOG2_W-1:0]  width_log2,
  input  logic [mbd_pkg::LOG2_W-1:0]  height_log2,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  mbd_pkg::comp_t              comp0,
  input  mbd_pkg::comp_t              comp1,
  input  mbd_pkg::comp_t              comp2,
  input  mbd_pkg::comp_t              comp3,
  input  logic                        q_ready,
  output logic                        q_push,
  output mbd_pkg::op_t                q_op,
  output logic                        q_last,
  output logic [ADDR_W-1:0]           q_addr,
  output logic [mbd_pkg::PAIR_W-1:0]  q_pair
);
  import mbd_pkg::*;

  localparam int COL_W = MAX_WIDTH_LOG2;

  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  comp_t             left_texel [COMP_COUNT];
  comp_t             cur        [COMP_COUNT];
  logic [LOG2_W-1:0] wl;
  logic [LOG2_W-1:0] hl;
  logic [COL_W-1:0]  last_col;
  logic [ROW_W-1:0]  last_row;
  logic              col_end;
  logic              row_end;
  logic              accept;

  assign cur[0] = comp0;
  assign cur[1] = comp1;
  assign cur[2] = comp2;
  assign cur[3] = comp3;

  // Clamp the size registers and turn them into last-index masks.
  always_comb begin
    if (width_log2 == '0) begin
      wl = LOG2_W'(1);
    end else if (width_log2 > LOG2_W'(MAX_WIDTH_LOG2)) begin
      wl = LOG2_W'(MAX_WIDTH_LOG2);
    end else begin
      wl = width_log2;
    end
    if (height_log2 == '0) begin
      hl = LOG2_W'(1);
    end else if (height_log2 > LOG2_W'(MAX_HEIGHT_LOG2)) begin
      hl = LOG2_W'(MAX_HEIGHT_LOG2);
    end else begin
      hl = height_log2;
    end
    for (int b = 0; b < COL_W; b++) begin
      last_col[b] = (b < int'(wl));
    end
    for (int b = 0; b < ROW_W; b++) begin
      last_row[b] = (b < int'(hl));
    end
  end

  assign col_end = (col >= last_col);
  assign row_end = (row >= last_row);

  // Even-column texels only update the left register, so they never wait.
  assign in_ready = !col[0] || q_ready;
  assign accept   = in_valid && in_ready;

  // Odd-column texels complete a pair and go to the back part.
  assign q_push = accept && col[0];
  assign q_op   = row[0] ? OP_EMIT : OP_STORE;
  assign q_last = col_end && row_end;
  assign q_addr = col[COL_W-1:1];

  always_comb begin
    for (int i = 0; i < COMP_COUNT; i++) begin
      q_pair[i*SUM_W +: SUM_W] = {1'b0, left_texel[i]} + {1'b0, cur[i]};
    end
  end

  // Left texel of the current pair.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < COMP_COUNT; i++) begin
        left_texel[i] <= '0;
      end
    end else if (accept && !col[0]) begin
      for (int i = 0; i < COMP_COUNT; i++) begin
        left_texel[i] <= cur[i];
      end
    end
  end

  // Raster position of the next texel.
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col_end) begin
        col <= '0;
        row <= row_end ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

endmodule

/* sv/mbd_back.sv */
// Back part: writes pair sums to the line store, reads them back and averages.
module mbd_back #(
  parameter int MAX_WIDTH_LOG2 = mbd_pkg::MAX_WIDTH_LOG2_DEFAULT,
  localparam int ADDR_W = MAX_WIDTH_LOG2 - 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [mbd_pkg::CCOUNT_W-1:0] component_count,
  input  logic                         q_valid,
  output logic                         q_pop,
  input  mbd_pkg::op_t                 q_op,
  input  logic                         q_last,
  input  logic [ADDR_W-1:0]            q_addr,
  input  logic [mbd_pkg::PAIR_W-1:0]   q_pair,
  output logic                         out_valid,
  input  logic                         out_ready,
  output mbd_pkg::comp_t               avg0,
  output mbd_pkg::comp_t               avg1,
  output mbd_pkg::comp_t               avg2,
  output mbd_pkg::comp_t               avg3,
  output logic                         last_of_image
);
  import mbd_pkg::*;

  localparam int LINE_DEPTH = 1 << ADDR_W;

  logic              head_emit;
  logic              s1_valid;
  logic [PAIR_W-1:0] s1_pair;
  logic              s1_last;
  logic              s1_free;
  logic              out_load;
  logic [PAIR_W-1:0] above;
  comp_t             avg      [COMP_COUNT];
  comp_t             avg_next [COMP_COUNT];
  logic [SUM_W+1:0]  quad_sum [COMP_COUNT];

  assign head_emit = (q_op == OP_EMIT);
  assign out_load  = s1_valid && (!out_valid || out_ready);
  assign s1_free   = !s1_valid || out_load;

  // Stores never stall; an emit waits for the read stage to free up.
  assign q_pop = q_valid && (!head_emit || s1_free);

  // Line store of pair sums from the even row.
  mbd_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (q_pop && !head_emit),
    .waddr (q_addr),
    .wdata (q_pair),
    .re    (q_pop && head_emit),
    .raddr (q_addr),
    .rdata (above)
  );

  // Read stage: pair sum waiting for the row above.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (q_pop && head_emit) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && head_emit) begin
      s1_pair <= q_pair;
      s1_last <= q_last;
    end
  end

  // Rounded quad average; unused components read as zero.
  always_comb begin
    for (int i = 0; i < COMP_COUNT; i++) begin
      quad_sum[i] = (SUM_W+2)'(above[i*SUM_W +: SUM_W])
                  + (SUM_W+2)'(s1_pair[i*SUM_W +: SUM_W])
                  + (SUM_W+2)'(1);
      avg_next[i] = (CCOUNT_W'(i) < component_count) ? quad_sum[i][COMP_W+1:2] : '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int i = 0; i < COMP_COUNT; i++) begin
        avg[i] <= avg_next[i];
      end
      last_of_image <= s1_last;
    end
  end

  assign avg0 = avg[0];
  assign avg1 = avg[1];
  assign avg2 = avg[2];
  assign avg3 = avg[3];

endmodule

/* test/mbd_quad_checker.sv */
// Checker that predicts and compares the output words of the mipmap downsampler.
module mbd_quad_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [mbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  mbd_pkg::comp_t                 comp0,
  input  mbd_pkg::comp_t                 comp1,
  input  mbd_pkg::comp_t                 comp2,
  input  mbd_pkg::comp_t                 comp3,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  mbd_pkg::comp_t                 avg0,
  input  mbd_pkg::comp_t                 avg1,
  input  mbd_pkg::comp_t                 avg2,
  input  mbd_pkg::comp_t                 avg3,
  input  logic                           last_of_image,
  output int                             fail_count,
  output int                             words_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import mbd_pkg::*;

  localparam int LINE_DEPTH = 1 << (MAX_WIDTH_LOG2_DEFAULT - 1);

  typedef comp_t [COMP_COUNT-1:0] texel_t;
  typedef sum_t  [COMP_COUNT-1:0] pair_t;

  typedef struct packed {
    texel_t avg;
    logic   last;
  } quad_word_t;

  // Shadow of the configuration registers.
  logic [LOG2_W-1:0]   width_log2;
  logic [LOG2_W-1:0]   height_log2;
  logic [CCOUNT_W-1:0] comp_count;

  // Shadow of the block's position and pairing state.
  logic [MAX_WIDTH_LOG2_DEFAULT-1:0] next_col;
  logic [ROW_W-1:0]                  next_row;
  texel_t                            left_texel;
  pair_t                             pair_line [LINE_DEPTH];

  // Averages still owed by the block, oldest first.
  quad_word_t quad_q [$];

  function automatic int unsigned clamp_log2(input logic [LOG2_W-1:0] v,
                                             input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Fold one accepted texel into the running 2x2 sums; odd-row odd-column
  // texels complete a quad and owe one word.
  task automatic fold_texel(input texel_t cur);
    int unsigned    last_col;
    int unsigned    last_row;
    pair_t          pair;
    pair_t          above;
    quad_word_t     word;
    logic [10:0]    quad_sum;
    last_col = (1 << clamp_log2(width_log2, MAX_WIDTH_LOG2_DEFAULT)) - 1;
    last_row = (1 << clamp_log2(height_log2, MAX_HEIGHT_LOG2)) - 1;
    if (!next_col[0]) begin
      left_texel = cur;
    end else begin
      for (int i = 0; i < COMP_COUNT; i++) begin
        pair[i] = sum_t'(left_texel[i]) + sum_t'(cur[i]);
      end
      if (!next_row[0]) begin
        pair_line[(next_col >> 1) % LINE_DEPTH] = pair;
      end else begin
        above = pair_line[(next_col >> 1) % LINE_DEPTH];
        for (int i = 0; i < COMP_COUNT; i++) begin
          quad_sum = 11'(above[i]) + 11'(pair[i]) + 11'd1;
          word.avg[i] = (i < comp_count) ? quad_sum[9:2] : '0;
        end
        word.last = (next_col >= last_col) && (next_row >= last_row);
        quad_q.push_back(word);
      end
    end
    // Raster advance with wrap at the end of a row and of the image.
    if (next_col >= last_col) begin
      next_col = '0;
      next_row = (next_row >= last_row) ? '0 : next_row + 1'b1;
    end else begin
      next_col = next_col + 1'b1;
    end
  endtask

  // Compare one accepted output word with the oldest owed one.
  task automatic check_word(input quad_word_t got);
    quad_word_t want;
    if (quad_q.size() == 0) begin
      fail_count++;
      $error("output word with none owed: avg0=%0d avg1=%0d avg2=%0d avg3=%0d last=%0d",
             got.avg[0], got.avg[1], got.avg[2], got.avg[3], got.last);
      return;
    end
    want = quad_q.pop_front();
    for (int i = 0; i < COMP_COUNT; i++) begin
      if (got.avg[i] !== want.avg[i]) begin
        fail_count++;
        $error("avg%0d mismatch: expected %0d, actual %0d", i, want.avg[i], got.avg[i]);
      end
    end
    if (got.last !== want.last) begin
      fail_count++;
      $error("last_of_image mismatch: expected %0d, actual %0d", want.last, got.last);
    end
  endtask

  // Watch all three channels at each rising edge.
  always @(posedge clk) begin
    if (rst) begin
      width_log2  = WIDTH_LOG2_RESET;
      height_log2 = HEIGHT_LOG2_RESET;
      comp_count  = COMP_COUNT_RESET;
      next_col    = '0;
      next_row    = '0;
      left_texel  = '0;
      fail_count  = 0;
      quad_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_IDX_WIDTH_LOG2:  width_log2  = cfg_data;
          CFG_IDX_HEIGHT_LOG2: height_log2 = cfg_data;
          CFG_IDX_COMP_COUNT:  comp_count  = cfg_data[CCOUNT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        check_word({avg3, avg2, avg1, avg0, last_of_image});
      end
      if (in_valid && in_ready) begin
        fold_texel({comp3, comp2, comp1, comp0});
      end
    end
    words_due = quad_q.size();
  end

endmodule

/* test/mipmap_box_downsample_tb.sv */
// Testbench top for the mipmap downsampler: stimulus, flow control and verdict.
module mipmap_box_downsample_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mbd_pkg::*;

  // Index with no register behind it; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_TEXELS  = 130;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 10;

  // Directed quads for the reset 2x2 image: all zero, saturated, alternating
  // bit patterns, then rounding at the bottom and at the top of the range.
  localparam logic [31:0] DIRECTED_TEXELS [20] = '{
    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
    32'hAA55_F00F, 32'h55AA_0FF0, 32'h0F0F_3CC3, 32'hF0F0_C33C,
    32'h0101_0101, 32'h0101_0100, 32'h0101_0000, 32'h0100_0000,
    32'hFEFF_FFFF, 32'hFEFE_FFFF, 32'hFEFE_FEFF, 32'hFEFE_FEFE
  };

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  comp_t                 comp0 = '0;
  comp_t                 comp1 = '0;
  comp_t                 comp2 = '0;
  comp_t                 comp3 = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  comp_t                 avg0;
  comp_t                 avg1;
  comp_t                 avg2;
  comp_t                 avg3;
  logic                  last_of_image;

  int fail_count;
  int words_due;

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic rx_hold = 1'b0;
  logic pressure_on = 1'b0;

  // Image size as last written, used to send whole images only.
  logic [LOG2_W-1:0] width_sel = WIDTH_LOG2_RESET;
  logic [LOG2_W-1:0] height_sel = HEIGHT_LOG2_RESET;

  always #5 clk = ~clk;

  mipmap_box_downsample dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .comp0         (comp0),
    .comp1         (comp1),
    .comp2         (comp2),
    .comp3         (comp3),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .avg0          (avg0),
    .avg1          (avg1),
    .avg2          (avg2),
    .avg3          (avg3),
    .last_of_image (last_of_image)
  );

  mbd_quad_checker quad_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .comp0         (comp0),
    .comp1         (comp1),
    .comp2         (comp2),
    .comp3         (comp3),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .avg0          (avg0),
    .avg1          (avg1),
    .avg2          (avg2),
    .avg3          (avg3),
    .last_of_image (last_of_image),
    .fail_count    (fail_count),
    .words_due     (words_due)
  );

  // Receiver: random stalls, overridden by the long hold-off.
  always @(negedge clk) begin
    out_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // Long receiver hold-off so that the block fills and stalls its input.
  initial begin
    wait (pressure_on);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  // Run limit.
  initial begin
    #10ms;
    $display("mipmap_box_downsample regression: fail");
    $finish;
  end

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      IDLE_SEND: begin
        send_idle_pct = 80;
        recv_stall_pct = 0;
      end
      IDLE_RECV: begin
        send_idle_pct = 0;
        recv_stall_pct = 80;
      end
      default: begin
        send_idle_pct = 26;
        recv_stall_pct = 26;
      end
    endcase
  endtask

  // One register write; valid stays up for a following write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic configure(input logic [LOG2_W-1:0] w, input logic [LOG2_W-1:0] h,
                           input logic [CFG_DATA_W-1:0] count);
    write_reg(CFG_IDX_WIDTH_LOG2, w);
    write_reg(CFG_IDX_HEIGHT_LOG2, h);
    write_reg(CFG_IDX_COMP_COUNT, count);
    if ($urandom_range(3) == 0) write_reg(CFG_IDX_UNUSED, 4'($urandom));
    cfg_valid <= 1'b0;
    width_sel = w;
    height_sel = h;
  endtask

  function automatic int image_texels();
    int wl;
    int hl;
    wl = (width_sel == 0) ? 1 :
         (width_sel > MAX_WIDTH_LOG2_DEFAULT) ? MAX_WIDTH_LOG2_DEFAULT : width_sel;
    hl = (height_sel == 0) ? 1 :
         (height_sel > MAX_HEIGHT_LOG2) ? MAX_HEIGHT_LOG2 : height_sel;
    return 1 << (wl + hl);
  endfunction

  // Mostly random bytes; now and then each byte pinned to 0 or 255.
  function automatic logic [31:0] random_texel();
    logic [31:0] t;
    t = $urandom;
    if ($urandom_range(7) == 0) begin
      for (int b = 0; b < 4; b++) t[8*b +: 8] = {8{t[b]}};
    end
    return t;
  endfunction

  // Offer one texel word and hold it until accepted.
  task automatic send_texel(input logic [31:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    {comp3, comp2, comp1, comp0} <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Whole images only, so every line-store read follows its write.
  task automatic send_images(input int min_texels);
    int sent;
    sent = 0;
    do begin
      repeat (image_texels()) send_texel(random_texel());
      sent += image_texels();
    end while (sent < min_texels);
  endtask

  // Wait until every owed word has left and the pipeline has settled.
  task automatic drain();
    in_valid <= 1'b0;
    wait (words_due == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [LOG2_W-1:0] w;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed quads at the reset configuration.
    set_idling(IDLE_NONE);
    foreach (DIRECTED_TEXELS[i]) send_texel(DIRECTED_TEXELS[i]);
    drain();

    // Out-of-range register values on small images, one image each.
    configure(4'd0, 4'd0, 4'd0);
    send_images(1);
    drain();
    set_idling(IDLE_RECV);
    configure(4'd1, 4'd0, 4'd7);
    send_images(1);
    drain();
    set_idling(IDLE_BOTH);
    configure(4'd0, 4'd3, 4'd5);
    send_images(1);
    drain();

    // Random small images under each flow-control pattern.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_idling(idle_mode_t'(p % 4));
      if (p == 0) begin
        configure(4'd6, 4'd2, 4'd4);
        pressure_on = 1'b1;
      end else begin
        w = ($urandom_range(3) == 0) ? 4'($urandom_range(6, 4)) : 4'($urandom_range(3));
        configure(w, 4'($urandom_range(3)), 4'($urandom));
      end
      send_images(PHASE_TEXELS);
      drain();
    end

    if (fail_count == 0 && words_due == 0) begin
      $display("mipmap_box_downsample regression: pass");
    end else begin
      $display("mipmap_box_downsample regression: fail");
    end
    $finish;
  end

endmodule
